// File: rtl/tlsd_pkg.sv
package tlsd_pkg;

    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned INSN_W    = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [INSN_W-1:0] MASK_REG_FORM = 16'hFE00;
    localparam logic [INSN_W-1:0] MASK_IMM_FORM = 16'hF800;

    localparam logic [INSN_W-1:0] OP_STR_REG   = 16'h5000;
    localparam logic [INSN_W-1:0] OP_STRH_REG  = 16'h5200;
    localparam logic [INSN_W-1:0] OP_STRB_REG  = 16'h5400;
    localparam logic [INSN_W-1:0] OP_LDRSB_REG = 16'h5600;
    localparam logic [INSN_W-1:0] OP_LDR_REG   = 16'h5800;
    localparam logic [INSN_W-1:0] OP_LDRH_REG  = 16'h5A00;
    localparam logic [INSN_W-1:0] OP_LDRB_REG  = 16'h5C00;
    localparam logic [INSN_W-1:0] OP_LDRSH_REG = 16'h5E00;

    localparam logic [INSN_W-1:0] OP_STR_IMM   = 16'h6000;
    localparam logic [INSN_W-1:0] OP_LDR_IMM   = 16'h6800;
    localparam logic [INSN_W-1:0] OP_STRB_IMM  = 16'h7000;
    localparam logic [INSN_W-1:0] OP_LDRB_IMM  = 16'h7800;
    localparam logic [INSN_W-1:0] OP_STRH_IMM  = 16'h8000;
    localparam logic [INSN_W-1:0] OP_LDRH_IMM  = 16'h8800;
    localparam logic [INSN_W-1:0] OP_STR_SP    = 16'h9000;
    localparam logic [INSN_W-1:0] OP_LDR_SP    = 16'h9800;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [2:0] PC_STEP_THUMB = 3'd2;

    typedef struct packed {
        logic              cmd;
        logic [3:0]        reg_index;
        logic [31:0]       reg_value;
        logic [15:0]       instruction;
    } t_in_item;

    typedef struct packed {
        logic              matched;
        logic              is_load;
        logic [31:0]       effective_address;
        logic [2:0]        target_reg;
        logic [1:0]        access_size;
        logic              sign_extend;
        logic [2:0]        pc_step;
    } t_out_item;

endpackage

// File: rtl/tlsd_decode.sv
module tlsd_decode (
    input  logic [15:0]          i_instruction,
    input  logic [31:0]          i_rn_value,
    input  logic [31:0]          i_rm_value,
    input  logic [31:0]          i_sp_value,
    output tlsd_pkg::t_out_item  o_result
);
    import tlsd_pkg::*;

    logic [2:0]  rt;
    logic [2:0]  rt_sp;
    logic [4:0]  imm5;
    logic [7:0]  imm8;
    logic [31:0] addr_reg;
    logic [31:0] addr_word;
    logic [31:0] addr_half;
    logic [31:0] addr_byte;
    logic [31:0] addr_sp;

    assign rt    = i_instruction[2:0];
    assign rt_sp = i_instruction[10:8];
    assign imm5  = i_instruction[10:6];
    assign imm8  = i_instruction[7:0];

    assign addr_reg  = i_rn_value + i_rm_value;
    assign addr_word = i_rn_value + {25'd0, imm5, 2'b00};
    assign addr_half = i_rn_value + {26'd0, imm5, 1'b0};
    assign addr_byte = i_rn_value + {27'd0, imm5};
    assign addr_sp   = i_sp_value + {22'd0, imm8, 2'b00};

    always_comb begin
        o_result = '0;
        case (i_instruction & MASK_REG_FORM)
            OP_STR_REG: begin
                o_result = '{1'b1, 1'b0, addr_reg, rt, SZ_WORD, 1'b0, PC_STEP_THUMB};
            end
            OP_STRH_REG: begin
                o_result = '{1'b1, 1'b0, addr_reg, rt, SZ_HALF, 1'b0, PC_STEP_THUMB};
            end
            OP_STRB_REG: begin
                o_result = '{1'b1, 1'b0, addr_reg, rt, SZ_BYTE, 1'b0, PC_STEP_THUMB};
            end
            OP_LDRSB_REG: begin
                o_result = '{1'b1, 1'b1, addr_reg, rt, SZ_BYTE, 1'b1, PC_STEP_THUMB};
            end
            OP_LDR_REG: begin
                o_result = '{1'b1, 1'b1, addr_reg, rt, SZ_WORD, 1'b0, PC_STEP_THUMB};
            end
            OP_LDRH_REG: begin
                o_result = '{1'b1, 1'b1, addr_reg, rt, SZ_HALF, 1'b0, PC_STEP_THUMB};
            end
            OP_LDRB_REG: begin
                o_result = '{1'b1, 1'b1, addr_reg, rt, SZ_BYTE, 1'b0, PC_STEP_THUMB};
            end
            OP_LDRSH_REG: begin
                o_result = '{1'b1, 1'b1, addr_reg, rt, SZ_HALF, 1'b1, PC_STEP_THUMB};
            end
            default: begin
                case (i_instruction & MASK_IMM_FORM)
                    OP_STR_IMM: begin
                        o_result = '{1'b1, 1'b0, addr_word, rt, SZ_WORD, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_LDR_IMM: begin
                        o_result = '{1'b1, 1'b1, addr_word, rt, SZ_WORD, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_STRB_IMM: begin
                        o_result = '{1'b1, 1'b0, addr_byte, rt, SZ_BYTE, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_LDRB_IMM: begin
                        o_result = '{1'b1, 1'b1, addr_byte, rt, SZ_BYTE, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_STRH_IMM: begin
                        o_result = '{1'b1, 1'b0, addr_half, rt, SZ_HALF, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_LDRH_IMM: begin
                        o_result = '{1'b1, 1'b1, addr_half, rt, SZ_HALF, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_STR_SP: begin
                        o_result = '{1'b1, 1'b0, addr_sp, rt_sp, SZ_WORD, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    OP_LDR_SP: begin
                        o_result = '{1'b1, 1'b1, addr_sp, rt_sp, SZ_WORD, 1'b0,
                                     PC_STEP_THUMB};
                    end
                    default: begin
                        o_result = '0;
                    end
                endcase
            end
        endcase
    end

endmodule

// File: rtl/thumb_load_store_decoder.sv
// Decodes 16-bit Thumb single-register load/store halfwords against a 16-entry
// register file. A write transaction (cmd 0) updates one register and gives no
// result; a decode transaction (cmd 1) gives exactly one result, with matched
// cleared and all other fields zero when the halfword is not a supported form.
// The block takes one transaction per cycle unless o_in_stall is high, as it is
// while a decode waits behind a stalled output. A decode transaction passes the
// registered read of the register file, then the registered decode and address
// add. A write is seen by any decode accepted in a later cycle. Registers read
// as zero until written; the SP-relative forms use register STACK_REG as the base.
module thumb_load_store_decoder #(
    parameter int unsigned STACK_REG = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlsd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlsd_pkg::t_out_item  o_out_data
);
    import tlsd_pkg::*;

    localparam logic [REG_IDX_W-1:0] SP_IDX = REG_IDX_W'(STACK_REG);

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_written;
    logic [DATA_W-1:0]    r_sp;

    logic                 r_s1_valid;
    logic [INSN_W-1:0]    r_s1_insn;
    logic [DATA_W-1:0]    r_s1_rn;
    logic [DATA_W-1:0]    r_s1_rm;
    logic                 r_s1_rn_ok;
    logic                 r_s1_rm_ok;
    logic [DATA_W-1:0]    r_s1_sp;

    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 out_free;
    logic                 in_accept;
    logic                 wr_en;
    logic                 dec_en;
    logic [2:0]           rn_idx;
    logic [2:0]           rm_idx;
    logic [DATA_W-1:0]    rn_value;
    logic [DATA_W-1:0]    rm_value;
    logic                 n_s1_valid;
    t_out_item            dec_result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign wr_en      = in_accept && (i_in_data.cmd == CMD_WRITE);
    assign dec_en     = in_accept && (i_in_data.cmd == CMD_DECODE);
    assign rn_idx     = i_in_data.instruction[5:3];
    assign rm_idx     = i_in_data.instruction[8:6];

    // register file, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_in_data.reg_index] <= i_in_data.reg_value;
        end
        if (dec_en) begin
            r_s1_rn <= r_mem[{1'b0, rn_idx}];
            r_s1_rm <= r_mem[{1'b0, rm_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_sp      <= '0;
        end else if (wr_en) begin
            r_written[i_in_data.reg_index] <= 1'b1;
            if (i_in_data.reg_index == SP_IDX) begin
                r_sp <= i_in_data.reg_value;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (dec_en) begin
            n_s1_valid = 1'b1;
        end else if (out_free) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_en) begin
            r_s1_insn  <= i_in_data.instruction;
            r_s1_sp    <= r_sp;
            r_s1_rn_ok <= r_written[{1'b0, rn_idx}];
            r_s1_rm_ok <= r_written[{1'b0, rm_idx}];
        end
    end

    // never-written registers read as zero
    assign rn_value = r_s1_rn_ok ? r_s1_rn : '0;
    assign rm_value = r_s1_rm_ok ? r_s1_rm : '0;

    tlsd_decode u_decode (
        .i_instruction (r_s1_insn),
        .i_rn_value    (rn_value),
        .i_rm_value    (rm_value),
        .i_sp_value    (r_s1_sp),
        .o_result      (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= dec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sim/tb_thumb_load_store_decoder.sv
module tb_thumb_load_store_decoder;
    import tlsd_pkg::*;

    localparam int unsigned STACK_REG    = 13;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned SEGMENT_LEN  = 290;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data  = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    t_idle_phase idle_mode   = PH_STEADY;
    logic        typed_valid = 1'b0;
    t_out_item   typed_want  = '0;

    logic [31:0] shadow_regs [REG_COUNT];
    t_out_item   expected_access_q [$];
    t_stim_row   directed_rows [$];
    int unsigned mismatch_count = 0;

    thumb_load_store_decoder #(
        .STACK_REG(STACK_REG)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < REG_COUNT; k++) begin
            shadow_regs[k] = '0;
        end
    end

    function automatic int unsigned send_idle_pct(t_idle_phase ph);
        case (ph)
            PH_SEND_IDLE: return 69;
            PH_BOTH_IDLE: return 29;
            default:      return 0;
        endcase
    endfunction

    function automatic int unsigned stall_pct(t_idle_phase ph);
        case (ph)
            PH_RECV_STALL: return 69;
            PH_BOTH_IDLE:  return 29;
            default:       return 0;
        endcase
    endfunction

    function automatic t_out_item build_access(logic load, logic [31:0] addr, logic [2:0] rt,
                                               logic [1:0] size, logic sx);
        t_out_item res;
        res.matched           = 1'b1;
        res.is_load           = load;
        res.effective_address = addr;
        res.target_reg        = rt;
        res.access_size       = size;
        res.sign_extend       = sx;
        res.pc_step           = PC_STEP_THUMB;
        return res;
    endfunction

    function automatic t_out_item predict_access(logic [15:0] ins);
        logic [2:0]  rt;
        logic [2:0]  rt_sp;
        logic [31:0] base;
        logic [31:0] roff;
        logic [31:0] sp;
        logic [31:0] imm5;
        logic [31:0] imm8;
        t_out_item   res;
        rt    = ins[2:0];
        rt_sp = ins[10:8];
        base  = shadow_regs[{1'b0, ins[5:3]}];
        roff  = base + shadow_regs[{1'b0, ins[8:6]}];
        sp    = shadow_regs[STACK_REG];
        imm5  = {27'd0, ins[10:6]};
        imm8  = {24'd0, ins[7:0]};
        res   = '0;
        case (ins & MASK_REG_FORM)
            OP_STR_REG:   res = build_access(1'b0, roff, rt, SZ_WORD, 1'b0);
            OP_STRH_REG:  res = build_access(1'b0, roff, rt, SZ_HALF, 1'b0);
            OP_STRB_REG:  res = build_access(1'b0, roff, rt, SZ_BYTE, 1'b0);
            OP_LDRSB_REG: res = build_access(1'b1, roff, rt, SZ_BYTE, 1'b1);
            OP_LDR_REG:   res = build_access(1'b1, roff, rt, SZ_WORD, 1'b0);
            OP_LDRH_REG:  res = build_access(1'b1, roff, rt, SZ_HALF, 1'b0);
            OP_LDRB_REG:  res = build_access(1'b1, roff, rt, SZ_BYTE, 1'b0);
            OP_LDRSH_REG: res = build_access(1'b1, roff, rt, SZ_HALF, 1'b1);
            default: begin
                case (ins & MASK_IMM_FORM)
                    OP_STR_IMM:  res = build_access(1'b0, base + (imm5 << 2), rt, SZ_WORD, 1'b0);
                    OP_LDR_IMM:  res = build_access(1'b1, base + (imm5 << 2), rt, SZ_WORD, 1'b0);
                    OP_STRB_IMM: res = build_access(1'b0, base + imm5, rt, SZ_BYTE, 1'b0);
                    OP_LDRB_IMM: res = build_access(1'b1, base + imm5, rt, SZ_BYTE, 1'b0);
                    OP_STRH_IMM: res = build_access(1'b0, base + (imm5 << 1), rt, SZ_HALF, 1'b0);
                    OP_LDRH_IMM: res = build_access(1'b1, base + (imm5 << 1), rt, SZ_HALF, 1'b0);
                    OP_STR_SP:   res = build_access(1'b0, sp + (imm8 << 2), rt_sp, SZ_WORD, 1'b0);
                    OP_LDR_SP:   res = build_access(1'b1, sp + (imm8 << 2), rt_sp, SZ_WORD, 1'b0);
                    default:     res = '0;
                endcase
            end
        endcase
        return res;
    endfunction

    function automatic logic [15:0] form_opcode(int unsigned k);
        case (k)
            0:  return OP_STR_REG;
            1:  return OP_STRH_REG;
            2:  return OP_STRB_REG;
            3:  return OP_LDRSB_REG;
            4:  return OP_LDR_REG;
            5:  return OP_LDRH_REG;
            6:  return OP_LDRB_REG;
            7:  return OP_LDRSH_REG;
            8:  return OP_STR_IMM;
            9:  return OP_LDR_IMM;
            10: return OP_STRB_IMM;
            11: return OP_LDRB_IMM;
            12: return OP_STRH_IMM;
            13: return OP_LDRH_IMM;
            14: return OP_STR_SP;
            default: return OP_LDR_SP;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned kind;
        int unsigned form;
        logic [15:0] mask;
        it.cmd         = CMD_DECODE;
        it.reg_index   = 4'($urandom_range(REG_COUNT - 1));
        it.reg_value   = $urandom;
        it.instruction = 16'($urandom);
        kind = $urandom_range(99);
        if (kind < 30) begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(7) == 0) begin
                it.reg_index = 4'(STACK_REG);
            end
            case ($urandom_range(9))
                0: it.reg_value = '0;
                1: it.reg_value = '1;
                2: it.reg_value = 32'h8000_0000;
                default: ;
            endcase
        end else if (kind < 88) begin
            form = $urandom_range(15);
            mask = (form < 8) ? MASK_REG_FORM : MASK_IMM_FORM;
            it.instruction = form_opcode(form) | (it.instruction & ~mask);
        end
        return it;
    endfunction

    task automatic add_write(logic [3:0] idx, logic [31:0] val);
        t_stim_row row;
        row = '0;
        row.item.cmd       = CMD_WRITE;
        row.item.reg_index = idx;
        row.item.reg_value = val;
        directed_rows.push_back(row);
    endtask

    task automatic add_decode(logic [15:0] ins, logic typed, t_out_item want);
        t_stim_row row;
        row = '0;
        row.item.cmd         = CMD_DECODE;
        row.item.instruction = ins;
        row.typed            = typed;
        row.want             = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(t_in_item it, logic typed, t_out_item want);
        while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_data   <= it;
        typed_valid <= typed;
        typed_want  <= want;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_access_q.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("unexpected transaction: m=%0d ld=%0d ea=%h rt=%0d sz=%0d sx=%0d pc=%0d",
                         got.matched, got.is_load, got.effective_address, got.target_reg,
                         got.access_size, got.sign_extend, got.pc_step);
            end
            mismatch_count++;
        end else begin
            want = expected_access_q.pop_front();
            if (got.matched !== want.matched || got.is_load !== want.is_load ||
                got.effective_address !== want.effective_address ||
                got.target_reg !== want.target_reg || got.access_size !== want.access_size ||
                got.sign_extend !== want.sign_extend || got.pc_step !== want.pc_step) begin
                if (mismatch_count < 10) begin
                    $display("mismatch: expected m=%0d ld=%0d ea=%h rt=%0d sz=%0d sx=%0d pc=%0d",
                             want.matched, want.is_load, want.effective_address,
                             want.target_reg, want.access_size, want.sign_extend, want.pc_step);
                    $display("          actual   m=%0d ld=%0d ea=%h rt=%0d sz=%0d sx=%0d pc=%0d",
                             got.matched, got.is_load, got.effective_address, got.target_reg,
                             got.access_size, got.sign_extend, got.pc_step);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct(idle_mode));
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out_data);
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_in_data.cmd == CMD_WRITE) begin
                    shadow_regs[i_in_data.reg_index] = i_in_data.reg_value;
                end else if (typed_valid) begin
                    expected_access_q.push_back(typed_want);
                end else begin
                    expected_access_q.push_back(predict_access(i_in_data.instruction));
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("thumb_load_store_decoder verification failed");
        $finish;
    end

    initial begin
        // register file reads zero right after reset
        add_decode(OP_LDR_IMM | 16'h07FF, 1'b1,
                   build_access(1'b1, 32'd124, 3'd7, SZ_WORD, 1'b0));
        add_decode(OP_LDR_SP | 16'h07FF, 1'b1,
                   build_access(1'b1, 32'd1020, 3'd7, SZ_WORD, 1'b0));
        // unsupported halfwords
        add_decode(16'h0000, 1'b1, '0);
        add_decode(16'hFFFF, 1'b1, '0);
        add_decode(16'h4FFF, 1'b1, '0);
        // values chosen so that addresses wrap
        add_write(4'd0, 32'hFFFF_FFFF);
        add_write(4'd1, 32'h0000_0001);
        add_write(4'd2, 32'h8000_0000);
        add_write(4'd7, 32'hFFFF_FFFF);
        add_write(4'(STACK_REG), 32'hFFFF_FFFC);
        add_decode(OP_STR_REG   | 16'h0043, 1'b0, '0);
        add_decode(OP_STRH_REG  | 16'h01C7, 1'b0, '0);
        add_decode(OP_STRB_REG  | 16'h0058, 1'b0, '0);
        add_decode(OP_LDRSB_REG | 16'h01FF, 1'b0, '0);
        add_decode(OP_LDR_REG   | 16'h0000, 1'b0, '0);
        add_decode(OP_LDRH_REG  | 16'h0081, 1'b0, '0);
        add_decode(OP_LDRB_REG  | 16'h0156, 1'b0, '0);
        add_decode(OP_LDRSH_REG | 16'h00D1, 1'b0, '0);
        add_decode(OP_STR_IMM   | 16'h07FF, 1'b0, '0);
        add_decode(OP_LDR_IMM   | 16'h0040, 1'b0, '0);
        add_decode(OP_STRB_IMM  | 16'h07C7, 1'b0, '0);
        add_decode(OP_LDRB_IMM  | 16'h0010, 1'b0, '0);
        add_decode(OP_STRH_IMM  | 16'h07F8, 1'b0, '0);
        add_decode(OP_LDRH_IMM  | 16'h0000, 1'b0, '0);
        add_decode(OP_STR_SP    | 16'h07FF, 1'b0, '0);
        add_decode(OP_LDR_SP    | 16'h0000, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                case (i / SEGMENT_LEN)
                    1:       idle_mode <= PH_SEND_IDLE;
                    2:       idle_mode <= PH_RECV_STALL;
                    3:       idle_mode <= PH_BOTH_IDLE;
                    default: idle_mode <= PH_STEADY;
                endcase
            end
            if (i == 2 * SEGMENT_LEN) begin
                // drain before the stall-heavy segment
                i_in_valid <= 1'b0;
                do begin
                    @(posedge i_clk);
                end while (expected_access_q.size() != 0);
            end
            send_item(random_item(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        do begin
            @(posedge i_clk);
        end while (expected_access_q.size() != 0);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_access_q.size() == 0) begin
            $display("thumb_load_store_decoder verification clean");
        end else begin
            $display("thumb_load_store_decoder verification failed");
        end
        $finish;
    end

endmodule
